// ===== design/hicu_pkg.sv =====
`timescale 1ns / 1ps

package hicu_pkg;

  localparam int MAX_DEGREE = 1023;
  localparam int FIELD_W    = 10;
  localparam int BIN_DEPTH  = MAX_DEGREE + 1;
  localparam int BIN_AW     = $clog2(BIN_DEPTH);
  localparam int CNT_W      = 10;
  localparam logic [CNT_W-1:0] BIN_MAX = {CNT_W{1'b1}};
  localparam int SUM_W      = BIN_AW + CNT_W;
  localparam int QDEPTH     = 2;
  localparam int QAW        = $clog2(QDEPTH);
  localparam int QCW        = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [FIELD_W-1:0] degree;
    logic [FIELD_W-1:0] current_core;
    logic [FIELD_W-1:0] neighbor_core;
    logic               has_neighbor;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_W-1:0] new_core;
    logic               changed;
  } out_word_t;

  typedef struct packed {
    logic               count;
    logic               scan;
    logic [BIN_AW-1:0]  pos;
    logic [BIN_AW-1:0]  deg;
    logic [FIELD_W-1:0] core;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic scanning;
  } bk_stat_t;

  typedef enum logic [2:0] {
    BK_CLR,
    BK_IDLE,
    BK_CNT,
    BK_SRD,
    BK_SWR,
    BK_DONE
  } bk_state_t;

  function automatic logic [BIN_AW-1:0] sat_deg(input logic [FIELD_W-1:0] d);
    logic [BIN_AW-1:0] r;
    if (int'(d) > MAX_DEGREE) begin
      r = BIN_AW'(MAX_DEGREE);
    end else begin
      r = BIN_AW'(d);
    end
    return r;
  endfunction

endpackage

// ===== design/hicu_ram.sv =====
`timescale 1ns / 1ps

module hicu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/hicu_front.sv =====
`timescale 1ns / 1ps

module hicu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hicu_pkg::in_word_t in_word,
  input  logic               hold,
  output logic               q_valid,
  output hicu_pkg::cmd_t     q_cmd,
  input  logic               q_pop
);
  import hicu_pkg::*;

  cmd_t            slot_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]  fill_r, fill_nxt;
  cmd_t            cmd;
  logic            take;
  logic            push;

  always_comb begin
    cmd.deg   = sat_deg(in_word.degree);
    cmd.core  = in_word.current_core;
    cmd.count = in_word.has_neighbor;
    cmd.scan  = in_word.last;
    cmd.pos   = (in_word.neighbor_core < FIELD_W'(cmd.deg)) ?
                BIN_AW'(in_word.neighbor_core) : cmd.deg;
  end

  assign in_stall = hold || (fill_r == QCW'(QDEPTH));
  assign take     = in_valid && !in_stall;
  // drop words that neither count nor close a vertex
  assign push     = take && (cmd.count || cmd.scan);
  assign q_valid  = (fill_r != '0);
  assign q_cmd    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == QDEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == QDEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (!push && q_pop) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

// ===== design/hicu_back.sv =====
`timescale 1ns / 1ps

module hicu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  hicu_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output hicu_pkg::bk_stat_t  stat,
  output logic                out_valid,
  input  logic                out_stall,
  output hicu_pkg::out_word_t out_word
);
  import hicu_pkg::*;

  bk_state_t         state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [BIN_AW-1:0] idx_r, idx_nxt;
  logic              touched_r, touched_nxt;
  logic [BIN_AW-1:0] min_r, min_nxt;
  logic [BIN_AW-1:0] max_r, max_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              found_r, found_nxt;
  logic [BIN_AW-1:0] h_r, h_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  logic              we;
  logic [BIN_AW-1:0] waddr;
  logic [CNT_W-1:0]  wdata;
  logic [BIN_AW-1:0] raddr;
  logic [CNT_W-1:0]  rdata;
  logic [SUM_W-1:0]  acc;
  logic              hit;

  hicu_ram #(
    .WIDTH (CNT_W),
    .DEPTH (BIN_DEPTH)
  ) u_bins (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign acc = sum_r + SUM_W'(rdata);
  assign hit = (idx_r <= cmd_r.deg) && (acc >= SUM_W'(idx_r));

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    touched_nxt   = touched_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    sum_nxt       = sum_r;
    found_nxt     = found_r;
    h_nxt         = h_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    q_pop         = 1'b0;
    we            = 1'b0;
    waddr         = idx_r;
    wdata         = '0;
    raddr         = idx_r;
    case (state_r)
      BK_CLR: begin
        we = 1'b1;
        if (int'(idx_r) == BIN_DEPTH - 1) begin
          state_nxt = BK_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      BK_IDLE: begin
        raddr = q_cmd.pos;
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          sum_nxt   = '0;
          found_nxt = 1'b0;
          if (q_cmd.count) begin
            state_nxt = BK_CNT;
          end else begin
            idx_nxt   = (touched_r && max_r > q_cmd.deg) ? max_r : q_cmd.deg;
            state_nxt = BK_SRD;
          end
        end
      end
      BK_CNT: begin
        we    = 1'b1;
        waddr = cmd_r.pos;
        wdata = (rdata == BIN_MAX) ? rdata : rdata + 1'b1;
        touched_nxt = 1'b1;
        min_nxt = (touched_r && min_r < cmd_r.pos) ? min_r : cmd_r.pos;
        max_nxt = (touched_r && max_r > cmd_r.pos) ? max_r : cmd_r.pos;
        if (cmd_r.scan) begin
          idx_nxt   = (max_nxt > cmd_r.deg) ? max_nxt : cmd_r.deg;
          state_nxt = BK_SRD;
        end else begin
          state_nxt = BK_IDLE;
        end
      end
      BK_SRD: begin
        state_nxt = BK_SWR;
      end
      BK_SWR: begin
        // clear the bin while summing it
        we = 1'b1;
        if (!found_r && idx_r <= cmd_r.deg) begin
          sum_nxt = acc;
        end
        if (!found_r && hit) begin
          found_nxt = 1'b1;
          h_nxt     = idx_r;
        end
        if ((found_r || hit) && (!touched_r || idx_r <= min_r)) begin
          state_nxt = BK_DONE;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = BK_SRD;
        end
      end
      BK_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (FIELD_W'(h_r) < cmd_r.core) begin
            out_word_nxt.new_core = FIELD_W'(h_r);
            out_word_nxt.changed  = 1'b1;
          end else begin
            out_word_nxt.new_core = cmd_r.core;
            out_word_nxt.changed  = 1'b0;
          end
          touched_nxt = 1'b0;
          state_nxt   = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLR;
      idx_r       <= '0;
      touched_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      touched_r   <= touched_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    min_r      <= min_nxt;
    max_r      <= max_nxt;
    sum_r      <= sum_nxt;
    h_r        <= h_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_word      = out_word_r;
  assign stat.clearing = (state_r == BK_CLR);
  assign stat.scanning = (state_r == BK_SRD) || (state_r == BK_SWR);

endmodule

// ===== design/h_index_core_update.sv =====
`timescale 1ns / 1ps
// channel | ports                          | word
// input   | in_valid, in_stall, in_word    | degree, current_core, neighbor_core,
//         |                                | has_neighbor, last
// result  | out_valid, out_stall, out_word | new_core, changed
//
// A neighbour word passes through the bin update as a read, then a saturating write.
// A last word adds a scan that reads, then clears, each bin in turn, from the larger of
// degree and the highest bin touched down to the h-index or the lowest bin touched,
// whichever is lower, then a step that issues the result; a stalled result holds that step.
// After reset a clearing pass empties all 1024 bins; in_stall is high throughout.
// A two-word queue parts the input from the bin unit; the result is a register.

module h_index_core_update (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hicu_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output hicu_pkg::out_word_t out_word
);
  import hicu_pkg::*;

  logic     q_valid;
  cmd_t     q_cmd;
  logic     q_pop;
  bk_stat_t bk_stat;

  hicu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .hold     (bk_stat.clearing),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  hicu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .stat      (bk_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> bk_stat.clearing)
    else $error("no clearing pass after reset");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.clearing |-> (!out_valid && in_stall && !q_pop))
    else $error("activity during clearing pass");

  a_scan_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.scanning |-> !q_pop)
    else $error("queue popped during scan");

endmodule

// ===== sim/h_index_core_update_test.sv =====
`timescale 1ns / 1ps

module h_index_core_update_test;
  import hicu_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int GAP_MAX      = 6;
  localparam int RUN_MAX      = 12;
  localparam int SCAN_COST    = 2 * BIN_DEPTH + 8;
  localparam int RANDOM_WORDS = 170;
  localparam int SAT_WORDS    = 1030;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  logic [CNT_W-1:0] hist [0:BIN_DEPTH-1];
  out_word_t        core_q [$];
  out_word_t        want;

  int     errors        = 0;
  int     words_sent    = 0;
  int     vertices_sent = 0;
  int     results_seen  = 0;
  int     burst_left    = 0;
  int     hold_req      = 0;
  int     hold_left     = 0;
  int     mode          = 0;
  int     mode_left     = 0;
  int     run_left      = 0;
  bit     run_stall     = 1'b0;
  longint cycles        = 0;
  longint budget        = 0;

  h_index_core_update DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > budget) begin
      $display("Timed out after %0d cycles, %0d results outstanding", cycles, core_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: long hold when asked, otherwise stall in modes of random length
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end
    if (mode_left == 0) begin
      mode = $urandom_range(0, 2);
      mode_left = $urandom_range(50, 300);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          if (run_left == 0) begin
            run_stall = !run_stall;
            run_left = run_stall ? $urandom_range(1, RUN_MAX) : $urandom_range(1, 6);
          end
          run_left--;
          out_stall <= run_stall;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (core_q.size() == 0) begin
        errors++;
        $error("result with no vertex pending: new_core %0d changed %0b",
               out_word.new_core, out_word.changed);
      end else begin
        want = core_q.pop_front();
        results_seen++;
        if (out_word.new_core !== want.new_core) begin
          errors++;
          $error("new_core: expected %0d, got %0d", want.new_core, out_word.new_core);
        end
        if (out_word.changed !== want.changed) begin
          errors++;
          $error("changed: expected %0b, got %0b", want.changed, out_word.changed);
        end
      end
    end
  end

  task automatic update_core(input in_word_t w);
    int        deg;
    int        pos;
    int        sum;
    int        i;
    bit        found;
    logic [FIELD_W-1:0] h;
    out_word_t r;
    deg = (w.degree > MAX_DEGREE) ? MAX_DEGREE : int'(w.degree);
    if (w.has_neighbor) begin
      pos = (int'(w.neighbor_core) < deg) ? int'(w.neighbor_core) : deg;
      if (hist[pos] != BIN_MAX) hist[pos] = hist[pos] + 1'b1;
    end
    if (w.last) begin
      sum = 0;
      h = '0;
      found = 1'b0;
      for (i = deg; i >= 0 && !found; i--) begin
        sum += int'(hist[i]);
        if (sum >= i) begin
          h = FIELD_W'(i);
          found = 1'b1;
        end
      end
      foreach (hist[j]) hist[j] = '0;
      if (h < w.current_core) begin
        r.new_core = h;
        r.changed = 1'b1;
      end else begin
        r.new_core = w.current_core;
        r.changed = 1'b0;
      end
      core_q = {core_q, r};
      vertices_sent++;
      budget += 4 * SCAN_COST;
    end
  endtask

  task automatic send_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, GAP_MAX);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    update_core(w);
    words_sent++;
    burst_left--;
    budget += 4 * (2 + GAP_MAX + RUN_MAX + 4);
    @(negedge clk);
  endtask

  function automatic in_word_t make_word(input int deg, input int core, input int nbr,
                                         input bit has, input bit fin);
    in_word_t w;
    w.degree = FIELD_W'(deg);
    w.current_core = FIELD_W'(core);
    w.neighbor_core = FIELD_W'(nbr);
    w.has_neighbor = has;
    w.last = fin;
    return w;
  endfunction

  task automatic send_vertex(input int deg, input int core, input int n, input bit noisy);
    in_word_t w;
    int       k;
    int       nbr;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        nbr = $urandom_range(0, MAX_DEGREE);
      end else begin
        nbr = $urandom_range(0, (deg + 2 > MAX_DEGREE) ? MAX_DEGREE : deg + 2);
      end
      w = make_word(deg, core, nbr, (deg == 0) ? 1'($urandom_range(0, 1)) : 1'b1,
                    k == n - 1);
      if (noisy) begin
        if ($urandom_range(0, 1) == 0) w.degree = FIELD_W'($urandom_range(0, MAX_DEGREE));
        w.has_neighbor = 1'($urandom_range(0, 1));
      end
      send_word(w);
    end
  endtask

  task automatic test_degree_zero();
    send_word(make_word(0, 0, 0, 1'b0, 1'b1));
    send_word(make_word(0, MAX_DEGREE, MAX_DEGREE, 1'b1, 1'b1));
  endtask

  task automatic test_no_neighbour();
    send_word(make_word(5, 3, 7, 1'b0, 1'b0));
    send_word(make_word(5, 3, 2, 1'b0, 1'b1));
  endtask

  task automatic test_clamp_and_count();
    send_word(make_word(4, 4, 4, 1'b1, 1'b0));
    send_word(make_word(4, 4, 4, 1'b1, 1'b0));
    send_word(make_word(4, 4, 3, 1'b1, 1'b0));
    send_word(make_word(4, 4, 1, 1'b1, 1'b1));
    send_word(make_word(3, MAX_DEGREE, MAX_DEGREE, 1'b1, 1'b0));
    send_word(make_word(3, MAX_DEGREE, MAX_DEGREE, 1'b1, 1'b0));
    send_word(make_word(3, MAX_DEGREE, MAX_DEGREE, 1'b1, 1'b1));
    send_word(make_word(MAX_DEGREE, 0, MAX_DEGREE, 1'b1, 1'b0));
    send_word(make_word(MAX_DEGREE, 0, 0, 1'b0, 1'b1));
  endtask

  // bins above the final degree are ignored, and every bin must be empty afterwards
  task automatic test_varying_degree();
    send_word(make_word(10, MAX_DEGREE, 9, 1'b1, 1'b0));
    send_word(make_word(2, MAX_DEGREE, 9, 1'b1, 1'b0));
    send_word(make_word(5, MAX_DEGREE, 0, 1'b1, 1'b1));
    send_word(make_word(2, MAX_DEGREE, 2, 1'b1, 1'b0));
    send_word(make_word(1, MAX_DEGREE, 0, 1'b0, 1'b1));
    send_word(make_word(2, MAX_DEGREE, 2, 1'b1, 1'b1));
  endtask

  // a wrapping bin would leave 6 and give h-index 6
  task automatic test_bin_saturation();
    int k;
    for (k = 0; k < SAT_WORDS; k++) begin
      send_word(make_word(MAX_DEGREE, MAX_DEGREE, 600, 1'b1, k == SAT_WORDS - 1));
    end
  endtask

  task automatic test_backpressure();
    int k;
    hold_req = 1;
    for (k = 0; k < 12; k++) send_vertex(2, 2, 2, 1'b0);
  endtask

  task automatic test_random_vertices();
    int deg;
    int core;
    int n;
    int stop_at;
    stop_at = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      deg = ($urandom_range(0, 19) == 0) ? $urandom_range(41, MAX_DEGREE)
                                         : $urandom_range(0, 40);
      case ($urandom_range(0, 2))
        0: core = $urandom_range(0, MAX_DEGREE);
        1: core = deg;
        default: core = $urandom_range(0, deg);
      endcase
      if (deg == 0) begin
        n = 1;
      end else if (deg > 48) begin
        n = $urandom_range(1, 48);
      end else begin
        n = deg + $urandom_range(0, 4) - 2;
        if (n < 1) n = 1;
      end
      if ($urandom_range(0, 9) == 0) n = $urandom_range(1, 8);
      send_vertex(deg, core, n, $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    budget = 4 * (BIN_DEPTH + HOLD_CYCLES + 2 * SCAN_COST) + 10000;
    foreach (hist[j]) hist[j] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_degree_zero();
    test_no_neighbour();
    test_clamp_and_count();
    test_varying_degree();
    test_bin_saturation();
    test_backpressure();
    test_random_vertices();

    in_valid <= 1'b0;
    while (core_q.size() != 0) @(posedge clk);
    repeat (SCAN_COST) @(posedge clk);

    $display("Sent %0d words over %0d vertices, checked %0d results", words_sent,
             vertices_sent, results_seen);
    $display("Degrees up to %0d, saturated bins and a %0d-cycle output hold covered",
             MAX_DEGREE, HOLD_CYCLES);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/hicu_pkg.sv
design/hicu_ram.sv
design/hicu_front.sv
design/hicu_back.sv
design/h_index_core_update.sv
sim/h_index_core_update_test.sv
